[hdl/hbpe_pkg.sv]
// Shared types and constants for the Huffman bit-packing encoder.
package hbpe_pkg;

   // Fixed field widths of the request and response channels.
   localparam int SYM_W    = 8;
   localparam int CODE_W   = 32;
   localparam int LEN_W    = 6;
   localparam int KIND_W   = 2;
   localparam int BYTE_W   = 8;
   localparam int VBITS_W  = 4;
   localparam int PEND_W   = 7;
   localparam int PCNT_W   = 3;
   localparam int ACC_W    = CODE_W + PEND_W;
   localparam int LEFT_W   = 3;

   // Default configuration of the table.
   localparam int SYMBOLS_DEF      = 256;
   localparam int MAX_CODE_LEN_DEF = 32;

   // Request kinds carried in req_type.
   typedef enum logic [KIND_W-1:0] {
      REQ_LOAD   = 2'd0,
      REQ_ENCODE = 2'd1,
      REQ_FLUSH  = 2'd2
   } req_kind_type;

endpackage

[hdl/hbpe_req_if.sv]
// Request channel of the Huffman encoder: table loads, symbols and flushes.
interface hbpe_req_if;
   logic                          valid;
   logic                          ready;
   logic [hbpe_pkg::KIND_W-1:0]   req_type;
   logic [hbpe_pkg::SYM_W-1:0]    symbol;
   logic [hbpe_pkg::CODE_W-1:0]   code_bits;
   logic [hbpe_pkg::LEN_W-1:0]    code_len;

   modport source (output valid, req_type, symbol, code_bits, code_len, input ready);
   modport sink (input valid, req_type, symbol, code_bits, code_len, output ready);
endinterface

[hdl/hbpe_rsp_if.sv]
// Response channel of the Huffman encoder: packed output bytes.
interface hbpe_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [hbpe_pkg::BYTE_W-1:0]    out_byte;
   logic [hbpe_pkg::VBITS_W-1:0]   valid_bits;
   logic                           stream_end;

   modport source (output valid, out_byte, valid_bits, stream_end, input ready);
   modport sink (input valid, out_byte, valid_bits, stream_end, output ready);
endinterface

[hdl/hbpe_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module hbpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hdl/huffman_bit_packing_encoder.sv]
// Huffman encoder: loaded code table in RAM, bit packer and byte emitter.
//
// The encoder accepts one request per cycle, while the merge stage is free or
// hands its item on, into a two-step pipeline: the code table RAM is read when a
// request is taken, and the merge stage then merges the code with the pending
// bits. The table entries reset to empty through one valid flip-flop per symbol,
// so the block is ready right after reset with no clearing pass. A load skips the
// merge stage and an encode that completes no byte does not wait; an encode that
// completes bytes (up to four), or a flush, which always yields exactly one response,
// waits for the byte emitter, which sends one byte per cycle while the sink is
// ready. The response is registered, so new requests are taken while a byte waits.
module huffman_bit_packing_encoder #(
   parameter int SYMBOLS      = hbpe_pkg::SYMBOLS_DEF,
   parameter int MAX_CODE_LEN = hbpe_pkg::MAX_CODE_LEN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   hbpe_req_if.sink   req_chan,
   hbpe_rsp_if.source rsp_chan
);

   localparam int AW      = $clog2(SYMBOLS);
   localparam int ENTRY_W = hbpe_pkg::CODE_W + hbpe_pkg::LEN_W;
   localparam int LEN_CAP = (MAX_CODE_LEN < hbpe_pkg::CODE_W) ? MAX_CODE_LEN
                                                              : hbpe_pkg::CODE_W;
   localparam logic [hbpe_pkg::SYM_W:0]   SYM_LIMIT = (hbpe_pkg::SYM_W + 1)'(SYMBOLS);
   localparam logic [hbpe_pkg::LEN_W-1:0] LEN_MAX   = hbpe_pkg::LEN_W'(LEN_CAP);

   // Request decode.
   logic                         req_xfer;
   logic                         in_table;
   logic                         is_load;
   logic                         is_encode;
   logic                         is_flush;
   logic [AW-1:0]                sym_addr;
   logic [hbpe_pkg::LEN_W-1:0]   load_len;
   logic [hbpe_pkg::CODE_W-1:0]  load_code;

   // Code table valid bits.
   logic [SYMBOLS-1:0]           tbl_valid_ff;
   logic [SYMBOLS-1:0]           tbl_valid_in;
   logic [ENTRY_W-1:0]           tbl_rdata;

   // Merge stage.
   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   logic                         s1_flush_ff;
   logic                         s1_hit_ff;
   logic                         s1_adv;
   logic [hbpe_pkg::CODE_W-1:0]  s1_code;
   logic [hbpe_pkg::LEN_W-1:0]   s1_len;
   logic [hbpe_pkg::ACC_W-1:0]   s1_acc;
   logic [hbpe_pkg::LEN_W-1:0]   s1_total;
   logic [hbpe_pkg::LEFT_W-1:0]  s1_nbytes;
   logic [hbpe_pkg::ACC_W-1:0]   s1_rest;

   // Pending partial byte.
   logic [hbpe_pkg::PEND_W-1:0]  pend_bits_ff;
   logic [hbpe_pkg::PEND_W-1:0]  pend_bits_in;
   logic [hbpe_pkg::PCNT_W-1:0]  pend_cnt_ff;
   logic [hbpe_pkg::PCNT_W-1:0]  pend_cnt_in;

   // Byte emitter.
   logic [hbpe_pkg::ACC_W-1:0]   em_acc_ff;
   logic [hbpe_pkg::ACC_W-1:0]   em_acc_in;
   logic [hbpe_pkg::LEFT_W-1:0]  em_left_ff;
   logic [hbpe_pkg::LEFT_W-1:0]  em_left_in;
   logic                         em_flush_ff;
   logic                         em_flush_in;
   logic [hbpe_pkg::PCNT_W-1:0]  em_cnt_ff;
   logic [hbpe_pkg::PCNT_W-1:0]  em_cnt_in;
   logic                         em_push;
   logic                         em_free;
   logic                         em_load;

   // Response register.
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [hbpe_pkg::BYTE_W-1:0]  rsp_byte_ff;
   logic [hbpe_pkg::BYTE_W-1:0]  rsp_byte_in;
   logic [hbpe_pkg::VBITS_W-1:0] rsp_vbits_ff;
   logic [hbpe_pkg::VBITS_W-1:0] rsp_vbits_in;
   logic                         rsp_end_ff;
   logic                         rsp_end_in;

   // Classify the request and prepare a table entry for loads.
   always_comb begin
      is_load   = 1'b0;
      is_encode = 1'b0;
      is_flush  = 1'b0;
      case (req_chan.req_type)
         hbpe_pkg::REQ_LOAD:   is_load   = 1'b1;
         hbpe_pkg::REQ_ENCODE: is_encode = 1'b1;
         hbpe_pkg::REQ_FLUSH:  is_flush  = 1'b1;
         default: ;
      endcase
   end

   assign in_table  = {1'b0, req_chan.symbol} < SYM_LIMIT;
   assign sym_addr  = req_chan.symbol[AW-1:0];
   assign load_len  = (req_chan.code_len > LEN_MAX) ? LEN_MAX : req_chan.code_len;
   assign load_code = req_chan.code_bits & ~({hbpe_pkg::CODE_W{1'b1}} << load_len);

   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   // Code table storage: 32 code bits and the length per symbol.
   hbpe_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SYMBOLS)
   ) u_code_table (
      .clock (clock),
      .we    (req_xfer && is_load && in_table),
      .waddr (sym_addr),
      .wdata ({load_len, load_code}),
      .re    (req_xfer && is_encode),
      .raddr (sym_addr),
      .rdata (tbl_rdata)
   );

   // An entry reads as empty until its first load.
   always_comb begin
      tbl_valid_in = tbl_valid_ff;
      if (req_xfer && is_load && in_table) begin
         tbl_valid_in[sym_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_valid_ff <= '0;
      end else begin
         tbl_valid_ff <= tbl_valid_in;
      end
   end

   // Merge stage: append the code to the pending bits and count whole bytes.
   assign s1_code   = s1_hit_ff ? tbl_rdata[hbpe_pkg::CODE_W-1:0] : '0;
   assign s1_len    = s1_hit_ff ? tbl_rdata[ENTRY_W-1:hbpe_pkg::CODE_W] : '0;
   assign s1_acc    = {{hbpe_pkg::CODE_W{1'b0}}, pend_bits_ff}
                    | ({{hbpe_pkg::PEND_W{1'b0}}, s1_code} << pend_cnt_ff);
   assign s1_total  = {{(hbpe_pkg::LEN_W-hbpe_pkg::PCNT_W){1'b0}}, pend_cnt_ff} + s1_len;
   assign s1_nbytes = s1_total[hbpe_pkg::LEN_W-1:3];
   assign s1_rest   = s1_acc >> {s1_nbytes, 3'b000};

   assign em_push = (em_left_ff != '0) && (!rsp_valid_ff || rsp_chan.ready);
   assign em_free = (em_left_ff == '0)
                 || ((em_left_ff == hbpe_pkg::LEFT_W'(1)) && em_push);
   assign s1_adv  = s1_valid_ff && (em_free || (!s1_flush_ff && s1_nbytes == '0));
   assign em_load = s1_adv && (s1_flush_ff || s1_nbytes != '0);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = is_encode || is_flush;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_flush_ff <= is_flush;
         s1_hit_ff   <= in_table && tbl_valid_ff[sym_addr];
      end
   end

   // Pending bits move on when the merge stage hands its item on.
   always_comb begin
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      if (s1_adv) begin
         if (s1_flush_ff) begin
            pend_bits_in = '0;
            pend_cnt_in  = '0;
         end else begin
            pend_bits_in = s1_rest[hbpe_pkg::PEND_W-1:0];
            pend_cnt_in  = s1_total[hbpe_pkg::PCNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
      end else begin
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
      end
   end

   // Byte emitter: sends the low byte and shifts, one transfer per cycle while the response register can take it.
   always_comb begin
      em_acc_in   = em_acc_ff;
      em_left_in  = em_left_ff;
      em_flush_in = em_flush_ff;
      em_cnt_in   = em_cnt_ff;
      if (em_load) begin
         if (s1_flush_ff) begin
            em_acc_in   = {{hbpe_pkg::CODE_W{1'b0}}, pend_bits_ff};
            em_left_in  = hbpe_pkg::LEFT_W'(1);
            em_flush_in = 1'b1;
            em_cnt_in   = pend_cnt_ff;
         end else begin
            em_acc_in   = s1_acc;
            em_left_in  = s1_nbytes;
            em_flush_in = 1'b0;
            em_cnt_in   = '0;
         end
      end else if (em_push) begin
         em_acc_in  = em_acc_ff >> 8;
         em_left_in = em_left_ff - hbpe_pkg::LEFT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         em_left_ff  <= '0;
         em_flush_ff <= 1'b0;
      end else begin
         em_left_ff  <= em_left_in;
         em_flush_ff <= em_flush_in;
      end
   end

   always_ff @(posedge clock) begin
      em_acc_ff <= em_acc_in;
      em_cnt_ff <= em_cnt_in;
   end

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_vbits_in = rsp_vbits_ff;
      rsp_end_in   = rsp_end_ff;
      if (em_push) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = em_acc_ff[hbpe_pkg::BYTE_W-1:0];
         rsp_vbits_in = em_flush_ff ? {1'b0, em_cnt_ff} : hbpe_pkg::VBITS_W'(8);
         rsp_end_in   = em_flush_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff  <= rsp_byte_in;
      rsp_vbits_ff <= rsp_vbits_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_byte   = rsp_byte_ff;
   assign rsp_chan.valid_bits = rsp_vbits_ff;
   assign rsp_chan.stream_end = rsp_end_ff;

   // Pending bits above the pending count are always zero.
   assert property (@(posedge clock) disable iff (reset)
      (pend_bits_ff >> pend_cnt_ff) == '0)
      else $error("pending bits above count are not zero");

   // The emitter never holds more than four bytes.
   assert property (@(posedge clock) disable iff (reset)
      em_left_ff <= hbpe_pkg::LEFT_W'(4))
      else $error("emitter byte count out of range");

   // A flush hands exactly one byte to the emitter.
   assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_flush_ff) |=> (em_flush_ff && em_left_ff == hbpe_pkg::LEFT_W'(1)))
      else $error("flush did not load a single emitter byte");

   // Only the end-of-stream byte carries a partial bit count.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_end_ff) |-> rsp_vbits_ff == hbpe_pkg::VBITS_W'(8))
      else $error("full byte without eight valid bits");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_end_ff) |-> rsp_vbits_ff < hbpe_pkg::VBITS_W'(8))
      else $error("end-of-stream byte with too many valid bits");

endmodule

[dv/huffman_bit_packing_encoder_tb.sv]
// Self-checking testbench for the Huffman bit-packing encoder.
module huffman_bit_packing_encoder_tb;

   localparam int CLK_HALF    = 5;
   localparam int RESET_CYC   = 10;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYC   = 20;
   localparam int TABLE_DEPTH = hbpe_pkg::SYMBOLS_DEF;
   localparam int LEN_CAP     = (hbpe_pkg::MAX_CODE_LEN_DEF < hbpe_pkg::CODE_W)
                              ? hbpe_pkg::MAX_CODE_LEN_DEF : hbpe_pkg::CODE_W;

   // Request type that the block ignores.
   localparam logic [hbpe_pkg::KIND_W-1:0] REQ_UNUSED = 2'd3;

   // One packed output byte as seen on the response channel.
   typedef struct packed {
      logic [hbpe_pkg::BYTE_W-1:0]  data;
      logic [hbpe_pkg::VBITS_W-1:0] nbits;
      logic                         done;
   } packed_byte_type;

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   error_count = 0;
   bit   no_idle     = 1'b0;

   // Predicted code table and bit packer.
   logic [hbpe_pkg::CODE_W-1:0] table_code [TABLE_DEPTH];
   logic [hbpe_pkg::LEN_W-1:0]  table_len  [TABLE_DEPTH];
   logic [hbpe_pkg::PEND_W-1:0] pend_bits;
   logic [hbpe_pkg::PCNT_W-1:0] pend_cnt;
   packed_byte_type             expected_bytes [$];

   // Symbols loaded with a nonzero code length, used to build meaningful streams.
   logic [hbpe_pkg::SYM_W-1:0]  loaded_syms [$];

   hbpe_req_if req_chan ();
   hbpe_rsp_if rsp_chan ();

   huffman_bit_packing_encoder DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #CLK_HALF clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d bytes outstanding", $time, expected_bytes.size());
         $display("huffman_bit_packing_encoder_tb NOT OK");
         $finish;
      end
   end

   // Idle length: mostly none, sometimes short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Apply one accepted request to the predicted table and packer.
   task automatic predict_packing(input logic [hbpe_pkg::KIND_W-1:0] kind,
                                  input logic [hbpe_pkg::SYM_W-1:0] sym,
                                  input logic [hbpe_pkg::CODE_W-1:0] code,
                                  input logic [hbpe_pkg::LEN_W-1:0] len);
      logic [63:0]                acc;
      logic [63:0]                mask;
      logic [hbpe_pkg::LEN_W-1:0] kept_len;
      int                         total;
      int                         n;
      case (kind)
         hbpe_pkg::REQ_LOAD: begin
            kept_len = (len > LEN_CAP) ? hbpe_pkg::LEN_W'(LEN_CAP) : len;
            mask = (64'd1 << kept_len) - 64'd1;
            table_code[sym] = code & mask[hbpe_pkg::CODE_W-1:0];
            table_len[sym] = kept_len;
         end
         hbpe_pkg::REQ_ENCODE: begin
            acc = {57'd0, pend_bits} | ({32'd0, table_code[sym]} << pend_cnt);
            total = int'(pend_cnt) + int'(table_len[sym]);
            n = 0;
            while (total >= 8 && n < 4) begin
               expected_bytes.push_back('{data: acc[7:0], nbits: 4'd8, done: 1'b0});
               acc = acc >> 8;
               total -= 8;
               n++;
            end
            pend_bits = acc[hbpe_pkg::PEND_W-1:0];
            pend_cnt = total[hbpe_pkg::PCNT_W-1:0];
         end
         hbpe_pkg::REQ_FLUSH: begin
            expected_bytes.push_back('{data: {1'b0, pend_bits}, nbits: {1'b0, pend_cnt},
                                       done: 1'b1});
            pend_bits = '0;
            pend_cnt = '0;
         end
         default: begin
            // The unused request type changes nothing.
         end
      endcase
   endtask

   // Drive one request and hold it until the block takes it.
   task automatic issue_request(input logic [hbpe_pkg::KIND_W-1:0] kind,
                                input logic [hbpe_pkg::SYM_W-1:0] sym,
                                input logic [hbpe_pkg::CODE_W-1:0] code,
                                input logic [hbpe_pkg::LEN_W-1:0] len);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.req_type <= kind;
      req_chan.symbol <= sym;
      req_chan.code_bits <= code;
      req_chan.code_len <= len;
      do @(posedge clock); while (!req_chan.ready);
      predict_packing(kind, sym, code, len);
      if (kind == hbpe_pkg::REQ_LOAD && len != '0) begin
         loaded_syms.push_back(sym);
      end
   endtask

   // Compare every response transfer against the oldest predicted byte.
   always @(posedge clock) begin
      packed_byte_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected byte, expected none, actual %h/%0d/%b", $time,
                     rsp_chan.out_byte, rsp_chan.valid_bits, rsp_chan.stream_end);
            error_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_chan.out_byte !== want.data) begin
               $display("%0t: out_byte mismatch, expected %h, actual %h", $time,
                        want.data, rsp_chan.out_byte);
               error_count++;
            end
            if (rsp_chan.valid_bits !== want.nbits) begin
               $display("%0t: valid_bits mismatch, expected %0d, actual %0d", $time,
                        want.nbits, rsp_chan.valid_bits);
               error_count++;
            end
            if (rsp_chan.stream_end !== want.done) begin
               $display("%0t: stream_end mismatch, expected %b, actual %b", $time,
                        want.done, rsp_chan.stream_end);
               error_count++;
            end
         end
      end
   end

   // Response back-pressure: runs of ready broken by random stalls.
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Unloaded symbols emit nothing, an empty flush still returns a byte,
   // and the unused request type is ignored.
   task automatic test_empty_table();
      issue_request(hbpe_pkg::REQ_ENCODE, 8'd0, 32'hFFFF_FFFF, 6'd63);
      issue_request(hbpe_pkg::REQ_ENCODE, 8'd255, 32'd0, 6'd0);
      issue_request(hbpe_pkg::REQ_FLUSH, 8'd0, 32'd0, 6'd0);
      issue_request(REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
      issue_request(hbpe_pkg::REQ_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
   endtask

   // Code lengths at their extremes, saturation and bits above the length.
   task automatic test_code_lengths();
      issue_request(hbpe_pkg::REQ_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd0);
      issue_request(hbpe_pkg::REQ_ENCODE, 8'd0, 32'd0, 6'd0);
      issue_request(hbpe_pkg::REQ_LOAD, 8'd255, 32'hA5C3_0F69, 6'd32);
      issue_request(hbpe_pkg::REQ_LOAD, 8'd1, 32'hFFFF_FFFF, 6'd7);
      issue_request(hbpe_pkg::REQ_ENCODE, 8'd1, 32'd0, 6'd0);
      // Seven pending bits plus a full-length code give four bytes.
      issue_request(hbpe_pkg::REQ_ENCODE, 8'd255, 32'd0, 6'd0);
      issue_request(hbpe_pkg::REQ_FLUSH, 8'd0, 32'd0, 6'd0);
      issue_request(hbpe_pkg::REQ_LOAD, 8'd2, 32'h5A5A_C3C3, 6'd63);
      issue_request(hbpe_pkg::REQ_LOAD, 8'd3, 32'h0123_4567, 6'd33);
      issue_request(hbpe_pkg::REQ_ENCODE, 8'd2, 32'd0, 6'd0);
      issue_request(hbpe_pkg::REQ_ENCODE, 8'd3, 32'd0, 6'd0);
      issue_request(hbpe_pkg::REQ_LOAD, 8'd4, 32'hFFFF_FFFF, 6'd1);
      issue_request(hbpe_pkg::REQ_ENCODE, 8'd4, 32'd0, 6'd0);
      issue_request(hbpe_pkg::REQ_FLUSH, 8'd0, 32'd0, 6'd0);
      issue_request(hbpe_pkg::REQ_LOAD, 8'd5, 32'h0000_0080, 6'd8);
      issue_request(hbpe_pkg::REQ_ENCODE, 8'd5, 32'd0, 6'd0);
      issue_request(hbpe_pkg::REQ_FLUSH, 8'd0, 32'd0, 6'd0);
   endtask

   // Mostly well-formed streams: loads, encodes of loaded symbols and flushes,
   // with some noise mixed in.
   task automatic test_random_stream(input int item_total);
      int                         sent;
      int                         r;
      logic [hbpe_pkg::LEN_W-1:0] len;
      logic [hbpe_pkg::SYM_W-1:0] sym;
      sent = 0;
      while (sent < item_total) begin
         r = $urandom_range(0, 99);
         if (r < 20 || loaded_syms.size() == 0) begin
            r = $urandom_range(0, 19);
            if (r == 0) begin
               len = '0;
            end else if (r < 3) begin
               len = hbpe_pkg::LEN_W'($urandom_range(33, 63));
            end else begin
               len = hbpe_pkg::LEN_W'($urandom_range(1, 32));
            end
            issue_request(hbpe_pkg::REQ_LOAD, hbpe_pkg::SYM_W'($urandom_range(0, 255)),
                          $urandom, len);
            sent++;
         end else if (r < 82) begin
            sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
            issue_request(hbpe_pkg::REQ_ENCODE, sym, $urandom,
                          hbpe_pkg::LEN_W'($urandom_range(0, 63)));
            sent++;
         end else if (r < 90) begin
            issue_request(hbpe_pkg::REQ_FLUSH, hbpe_pkg::SYM_W'($urandom_range(0, 255)),
                          $urandom, hbpe_pkg::LEN_W'($urandom_range(0, 63)));
            sent++;
         end else if (r < 95) begin
            issue_request(hbpe_pkg::REQ_ENCODE, hbpe_pkg::SYM_W'($urandom_range(0, 255)),
                          $urandom, hbpe_pkg::LEN_W'($urandom_range(0, 63)));
            sent++;
         end else begin
            issue_request(REQ_UNUSED, hbpe_pkg::SYM_W'($urandom_range(0, 255)), $urandom,
                          hbpe_pkg::LEN_W'($urandom_range(0, 63)));
         end
      end
   endtask

   // Back-to-back encodes with no idling on either side.
   task automatic test_burst(input int item_total);
      int i;
      no_idle = 1'b1;
      issue_request(hbpe_pkg::REQ_LOAD, 8'd200, $urandom, 6'd31);
      issue_request(hbpe_pkg::REQ_LOAD, 8'd201, $urandom, 6'd3);
      for (i = 0; i < item_total; i++) begin
         issue_request(hbpe_pkg::REQ_ENCODE, hbpe_pkg::SYM_W'($urandom_range(200, 201)),
                       32'd0, 6'd0);
      end
      issue_request(hbpe_pkg::REQ_FLUSH, 8'd0, 32'd0, 6'd0);
      no_idle = 1'b0;
   endtask

   // Test sequence and end of run.
   initial begin
      int i;
      for (i = 0; i < TABLE_DEPTH; i++) begin
         table_code[i] = '0;
         table_len[i] = '0;
      end
      pend_bits = '0;
      pend_cnt = '0;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.req_type <= hbpe_pkg::REQ_LOAD;
      req_chan.symbol <= '0;
      req_chan.code_bits <= '0;
      req_chan.code_len <= '0;
      repeat (RESET_CYC) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_code_lengths();
      test_random_stream(130);
      test_burst(36);
      test_random_stream(10);

      req_chan.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
      if (error_count == 0 && expected_bytes.size() == 0) begin
         $display("huffman_bit_packing_encoder_tb OK");
      end else begin
         $display("huffman_bit_packing_encoder_tb NOT OK");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/hbpe_pkg.sv
hdl/hbpe_req_if.sv
hdl/hbpe_rsp_if.sv
hdl/hbpe_ram.sv
hdl/huffman_bit_packing_encoder.sv
dv/huffman_bit_packing_encoder_tb.sv
